### hw/rtl/hsvrgb_pkg.sv
// Types and constants shared by the hsv to rgb pixel pipeline.
// No dependencies.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int unsigned HUE_W      = 13;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned SCALED_W   = 16;   // values at a scale of 255*255
    localparam int unsigned FRAC_W     = 10;   // ramp 0..960
    localparam int unsigned PROD_W     = 26;   // chroma times ramp

    localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
    localparam logic [HUE_W-1:0] HUE_SPAN   = 13'd1920;

    // floor(t/15) = (t * RECIP_15) >> 24 for t below 2^20
    localparam logic [20:0] RECIP_15    = 21'd1118482;
    localparam int unsigned RECIP_15_SH = 24;
    // floor(y/255) = (y * RECIP_255) >> 23 for 16-bit y
    localparam logic [15:0] RECIP_255    = 16'd32897;
    localparam int unsigned RECIP_255_SH = 23;

    typedef enum logic [2:0] {
        SECT_RED_GREEN_UP   = 3'd0,
        SECT_GREEN_RED_DOWN = 3'd1,
        SECT_GREEN_BLUE_UP  = 3'd2,
        SECT_BLUE_GREEN_DN  = 3'd3,
        SECT_BLUE_RED_UP    = 3'd4,
        SECT_RED_BLUE_DN    = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_pixel_t;

    // after the front stage
    typedef struct packed {
        logic [SCALED_W-1:0] cp;
        logic [SCALED_W-1:0] mp;
        logic [FRAC_W-1:0]   frac;
        sector_t             sector;
    } front_t;

    // after the ramp stages
    typedef struct packed {
        logic [SCALED_W-1:0] cp;
        logic [SCALED_W-1:0] xp;
        logic [SCALED_W-1:0] mp;
        sector_t             sector;
    } ramp_t;

endpackage

### hw/rtl/hsvrgb_front.sv
// Front stage: chroma, offset, hue sector and ramp fraction.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_front import hsvrgb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  hsv_pixel_t in_pixel,
    output logic       out_valid,
    input  logic       out_ready,
    output front_t     out_data
);

    logic         valid_reg;
    logic         valid_next;
    front_t       data_reg;
    front_t       data_next;
    logic         load;
    logic [HUE_W-1:0] q;
    logic [HUE_W-1:0] hue_base;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next = data_reg;

        // hue mod 1920 by range
        priority if (in_pixel.hue >= 13'd7680) begin
            hue_base = 13'd7680;
        end else if (in_pixel.hue >= 13'd5760) begin
            hue_base = 13'd5760;
        end else if (in_pixel.hue >= 13'd3840) begin
            hue_base = 13'd3840;
        end else if (in_pixel.hue >= HUE_SPAN) begin
            hue_base = HUE_SPAN;
        end else begin
            hue_base = '0;
        end
        q = in_pixel.hue - hue_base;

        if (q < HUE_SECTOR) begin
            data_next.frac = q[FRAC_W-1:0];
        end else begin
            data_next.frac = FRAC_W'(HUE_SPAN - q);
        end

        // out-of-range hue stays in the last sector
        priority if (in_pixel.hue >= 13'd4800) begin
            data_next.sector = SECT_RED_BLUE_DN;
        end else if (in_pixel.hue >= 13'd3840) begin
            data_next.sector = SECT_BLUE_RED_UP;
        end else if (in_pixel.hue >= 13'd2880) begin
            data_next.sector = SECT_BLUE_GREEN_DN;
        end else if (in_pixel.hue >= HUE_SPAN) begin
            data_next.sector = SECT_GREEN_BLUE_UP;
        end else if (in_pixel.hue >= HUE_SECTOR) begin
            data_next.sector = SECT_GREEN_RED_DOWN;
        end else begin
            data_next.sector = SECT_RED_GREEN_UP;
        end

        data_next.cp = SCALED_W'(in_pixel.brightness) * SCALED_W'(in_pixel.saturation);
        // v*255 - cp, never negative
        data_next.mp = {in_pixel.brightness, 8'b0} - SCALED_W'(in_pixel.brightness)
                       - data_next.cp;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

`ifndef SYNTHESIS
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg.frac <= FRAC_W'(HUE_SECTOR)))
        else $error("ramp fraction above one");

    a_offset_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ((17'(data_reg.cp) + 17'(data_reg.mp)) <= 17'd65025))
        else $error("chroma plus offset above full scale");
`endif

endmodule

### hw/rtl/hsvrgb_ramp.sv
// Ramp stages: chroma times ramp fraction, then divide by 960.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_ramp import hsvrgb_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output ramp_t  out_data
);

    // stage a: product
    logic              a_valid_reg;
    logic              a_valid_next;
    logic              a_ready;
    logic [PROD_W-1:0] a_prod_reg;
    ramp_t             a_side_reg;     // xp field unused here
    // stage b: quotient
    logic              b_valid_reg;
    logic              b_valid_next;
    logic              b_ready;
    ramp_t             b_data_reg;
    ramp_t             b_data_next;
    logic [19:0]       t;
    logic [40:0]       t_scaled;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    // 960 = 64 * 15: shift, then reciprocal multiply
    assign t        = a_prod_reg[PROD_W-1:6];
    assign t_scaled = 41'(t) * 41'(RECIP_15);

    always_comb begin
        b_data_next    = a_side_reg;
        b_data_next.xp = t_scaled[RECIP_15_SH +: SCALED_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_prod_reg        <= PROD_W'(in_data.cp) * PROD_W'(in_data.frac);
            a_side_reg.cp     <= in_data.cp;
            a_side_reg.mp     <= in_data.mp;
            a_side_reg.xp     <= '0;
            a_side_reg.sector <= in_data.sector;
        end
        if (a_valid_reg && b_ready) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

`ifndef SYNTHESIS
    a_xp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (b_data_reg.xp <= b_data_reg.cp))
        else $error("secondary component above chroma");
`endif

endmodule

### hw/rtl/hsvrgb_mix.sv
// Output stage: sector placement, offset add and divide by 255.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_mix import hsvrgb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  ramp_t      in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output rgb_pixel_t out_pixel
);

    logic                valid_reg;
    logic                valid_next;
    rgb_pixel_t          pixel_reg;
    rgb_pixel_t          pixel_next;
    logic [SCALED_W-1:0] r_comp;
    logic [SCALED_W-1:0] g_comp;
    logic [SCALED_W-1:0] b_comp;
    logic [SCALED_W-1:0] r_sum;
    logic [SCALED_W-1:0] g_sum;
    logic [SCALED_W-1:0] b_sum;
    logic [31:0]         r_scaled;
    logic [31:0]         g_scaled;
    logic [31:0]         b_scaled;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        r_comp = '0;
        g_comp = '0;
        b_comp = '0;
        unique case (in_data.sector)
            SECT_RED_GREEN_UP: begin
                r_comp = in_data.cp;
                g_comp = in_data.xp;
            end
            SECT_GREEN_RED_DOWN: begin
                r_comp = in_data.xp;
                g_comp = in_data.cp;
            end
            SECT_GREEN_BLUE_UP: begin
                g_comp = in_data.cp;
                b_comp = in_data.xp;
            end
            SECT_BLUE_GREEN_DN: begin
                g_comp = in_data.xp;
                b_comp = in_data.cp;
            end
            SECT_BLUE_RED_UP: begin
                r_comp = in_data.xp;
                b_comp = in_data.cp;
            end
            default: begin
                r_comp = in_data.cp;
                b_comp = in_data.xp;
            end
        endcase

        // sums stay within v*255
        r_sum = r_comp + in_data.mp;
        g_sum = g_comp + in_data.mp;
        b_sum = b_comp + in_data.mp;

        r_scaled = 32'(r_sum) * 32'(RECIP_255);
        g_scaled = 32'(g_sum) * 32'(RECIP_255);
        b_scaled = 32'(b_sum) * 32'(RECIP_255);

        pixel_next.red   = r_scaled[RECIP_255_SH +: CHAN_W];
        pixel_next.green = g_scaled[RECIP_255_SH +: CHAN_W];
        pixel_next.blue  = b_scaled[RECIP_255_SH +: CHAN_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

### hw/rtl/hsv_to_rgb_pixel_unit.sv
// Four register stages (front, product, quotient, output); an accepted item passes through
// them in that order to m_valid. Throughput: one item per cycle while m_ready is high;
// each stage holds one level of multiplication and its register.
// Each stage stalls on its own, so bubbles close up under back-pressure.
// Reset (aresetn low, synchronous) empties every stage; no other state is kept.
// Top level of the hsv to rgb pixel pipeline; uses hsvrgb_pkg, hsvrgb_front,
// hsvrgb_ramp and hsvrgb_mix.
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_unit import hsvrgb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  hsv_pixel_t s_pixel,
    output logic       m_valid,
    input  logic       m_ready,
    output rgb_pixel_t m_pixel
);

    logic   front_valid;
    logic   front_ready;
    front_t front_data;
    logic   ramp_valid;
    logic   ramp_ready;
    ramp_t  ramp_data;

    hsvrgb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pixel  (s_pixel),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    hsvrgb_ramp u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (ramp_valid),
        .out_ready (ramp_ready),
        .out_data  (ramp_data)
    );

    hsvrgb_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ramp_valid),
        .in_ready  (ramp_ready),
        .in_data   (ramp_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pixel (m_pixel)
    );

`ifndef SYNTHESIS
    // a free output stage means the whole chain can take an item
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !ramp_valid && !front_valid) |-> s_ready)
        else $error("input stalled with an empty pipeline");
`endif

endmodule
